/* sv/source_text_tokenizer_defines.svh */
// Assertion macros for the tokenizer controller
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define STT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/stt_pkg.sv */
// Command and status types between the tokenizer controller and datapath
package stt_pkg;

  typedef struct packed {
    logic keep_in;     // store the accepted byte in the open token
    logic latch;       // hold the accepted byte that ends or follows a token
    logic emit_flush;  // send the next stored character
    logic emit_plus;   // send a '+' operator item
    logic tail_go;     // finish the held byte: own item and new token start
  } dp_cmd_t;

  typedef struct packed {
    logic in_keep;     // input byte extends the open token
    logic mode_flush;  // an identifier, number or string is open
    logic mode_plus;   // a lone '+' is waiting
    logic flush_last;  // the next flush item closes the token
    logic pair;        // a second '+' item is still due
    logic tail_res;    // the held byte gives an item of its own
    logic out_free;    // output register can take an item this cycle
  } dp_stat_t;

endpackage

/* sv/stt_dp.sv */
// Tokenizer datapath: character classes, token store, keyword match, output register
module stt_dp #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_text_byte,
  input  stt_pkg::dp_cmd_t  cmd,
  output stt_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_token_kind,
  output logic [7:0]        out_value_char,
  output logic              out_char_present,
  output logic              out_token_last,
  output logic              out_run_last
);
  import stt_pkg::*;

  localparam int LEN_W  = $clog2(MAX_TOKEN_LEN);
  localparam int DEPTH  = MAX_TOKEN_LEN - 1;
  localparam int ADDR_W = (MAX_TOKEN_LEN > 2) ? $clog2(MAX_TOKEN_LEN - 1) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN - 1);

  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_OPER    = 3'd4;
  localparam logic [2:0] KIND_SYMBOL  = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;
  localparam logic [2:0] KIND_END     = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam int KW_NUM = 5;
  localparam int KW_MAX = 6;
  // if, else, while, mod, return
  localparam logic [7:0] KW_CHR [0:KW_NUM-1][0:KW_MAX-1] = '{
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},
    '{8'h6D, 8'h6F, 8'h64, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}
  };
  localparam int KW_LEN [0:KW_NUM-1] = '{2, 4, 5, 3, 6};

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_IDENT  = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_STRING = 5'b01000,
    MODE_PLUS   = 5'b10000
  } scan_mode_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_symbol(input logic [7:0] b);
    logic hit;
    case (b)
      8'h3E, 8'h3C, 8'h3D, 8'h21, 8'h2A, 8'h2F, 8'h28, 8'h29,
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B, 8'h2C, 8'h2E: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Update per-keyword match flags for a character stored at position pos
  function automatic logic [KW_NUM-1:0] kw_step(input logic [KW_NUM-1:0] prev,
                                                input logic [LEN_W-1:0] pos,
                                                input logic [7:0] b);
    logic [KW_NUM-1:0] res;
    logic hit;
    for (int k = 0; k < KW_NUM; k++) begin
      hit = 1'b0;
      for (int j = 0; j < KW_MAX; j++) begin
        if (j < KW_LEN[k] && 32'(pos) == j && b == KW_CHR[k][j]) hit = 1'b1;
      end
      res[k] = hit && (pos == '0 || prev[k]);
    end
    return res;
  endfunction

  scan_mode_t          mode_r, mode_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [KW_NUM-1:0]   kwm_r, kwm_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [2:0]          kind_r, kind_nxt;
  logic                pair_r, pair_nxt;
  logic                tail_on_r, tail_on_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_kind_r, out_kind_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_present_r, out_present_nxt;
  logic                out_tlast_r, out_tlast_nxt;
  logic                out_rlast_r, out_rlast_nxt;
  logic                out_load;

  logic [7:0]          mem [0:DEPTH-1];
  logic [7:0]          rd_data_r;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [7:0]          wr_data;

  logic                in_ident_ch, in_keep, kw_hit, flush_last, tail_res, out_free;
  logic                held_start;

  assign in_ident_ch = is_letter(in_text_byte) || is_digit(in_text_byte)
                       || in_text_byte == CH_USCORE;

  always_comb begin
    case (mode_r)
      MODE_IDENT:  in_keep = in_ident_ch;
      MODE_NUMBER: in_keep = is_digit(in_text_byte);
      MODE_STRING: in_keep = in_text_byte != CH_NUL && in_text_byte != CH_QUOTE;
      default:     in_keep = 1'b0;
    endcase
  end

  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < KW_NUM; k++) begin
      if (kwm_r[k] && 32'(len_r) == KW_LEN[k]) kw_hit = 1'b1;
    end
  end

  assign flush_last = (len_r == '0) || (LEN_W'(idx_r) == len_r - LEN_W'(1));
  // Bytes that start a token or vanish give no item of their own
  assign held_start = is_space(byte_r) || is_letter(byte_r) || is_digit(byte_r)
                      || byte_r == CH_USCORE || byte_r == CH_QUOTE || byte_r == CH_PLUS;
  assign tail_res   = tail_on_r && (byte_r == CH_NUL || !held_start);
  assign out_free   = !out_valid_r || out_ready;

  assign stat.in_keep    = in_keep;
  assign stat.mode_flush = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER)
                           || (mode_r == MODE_STRING);
  assign stat.mode_plus  = mode_r == MODE_PLUS;
  assign stat.flush_last = flush_last;
  assign stat.pair       = pair_r;
  assign stat.tail_res   = tail_res;
  assign stat.out_free   = out_free;

  always_comb begin
    mode_nxt        = mode_r;
    len_nxt         = len_r;
    kwm_nxt         = kwm_r;
    byte_nxt        = byte_r;
    kind_nxt        = kind_r;
    pair_nxt        = pair_r;
    tail_on_nxt     = tail_on_r;
    idx_nxt         = idx_r;
    wr_en           = 1'b0;
    wr_addr         = len_r[ADDR_W-1:0];
    wr_data         = in_text_byte;
    rd_en           = 1'b0;
    rd_addr         = '0;
    out_load        = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_char_nxt    = out_char_r;
    out_present_nxt = out_present_r;
    out_tlast_nxt   = out_tlast_r;
    out_rlast_nxt   = out_rlast_r;

    if (cmd.keep_in && len_r < LEN_MAX) begin
      wr_en   = 1'b1;
      len_nxt = len_r + LEN_W'(1);
      kwm_nxt = kw_step(kwm_r, len_r, in_text_byte);
    end

    if (cmd.latch) begin
      byte_nxt    = in_text_byte;
      mode_nxt    = MODE_IDLE;
      pair_nxt    = (mode_r == MODE_PLUS) && in_text_byte == CH_PLUS;
      // closing quote and second '+' are consumed by the token they end
      tail_on_nxt = !(((mode_r == MODE_STRING) && in_text_byte == CH_QUOTE)
                      || ((mode_r == MODE_PLUS) && in_text_byte == CH_PLUS));
      case (mode_r)
        MODE_IDENT:  kind_nxt = kw_hit ? KIND_KEYWORD : KIND_IDENT;
        MODE_NUMBER: kind_nxt = KIND_NUMBER;
        default:     kind_nxt = KIND_STRING;
      endcase
      idx_nxt = '0;
      rd_en   = 1'b1;
    end

    if (cmd.emit_flush) begin
      out_load        = 1'b1;
      out_kind_nxt    = kind_r;
      out_char_nxt    = (len_r == '0) ? 8'h00 : rd_data_r;
      out_present_nxt = len_r != '0;
      out_tlast_nxt   = flush_last;
      out_rlast_nxt   = flush_last && !tail_res;
      if (flush_last) begin
        len_nxt = '0;
      end else begin
        idx_nxt = idx_r + ADDR_W'(1);
        rd_en   = 1'b1;
        rd_addr = idx_r + ADDR_W'(1);
      end
    end

    if (cmd.emit_plus) begin
      out_load        = 1'b1;
      out_kind_nxt    = KIND_OPER;
      out_char_nxt    = CH_PLUS;
      out_present_nxt = 1'b1;
      out_tlast_nxt   = !pair_r;
      out_rlast_nxt   = !pair_r && !tail_res;
      pair_nxt        = 1'b0;
    end

    if (cmd.tail_go) begin
      if (tail_res) begin
        out_load        = 1'b1;
        out_tlast_nxt   = 1'b1;
        out_rlast_nxt   = 1'b1;
        if (byte_r == CH_NUL) begin
          out_kind_nxt    = KIND_END;
          out_char_nxt    = 8'h00;
          out_present_nxt = 1'b0;
        end else begin
          out_kind_nxt    = is_symbol(byte_r) ? KIND_SYMBOL : KIND_UNKNOWN;
          out_char_nxt    = byte_r;
          out_present_nxt = 1'b1;
        end
      end
      if (tail_on_r) begin
        if (is_letter(byte_r) || byte_r == CH_USCORE || is_digit(byte_r)) begin
          mode_nxt = is_digit(byte_r) ? MODE_NUMBER : MODE_IDENT;
          wr_en    = 1'b1;
          wr_addr  = '0;
          wr_data  = byte_r;
          len_nxt  = LEN_W'(1);
          kwm_nxt  = kw_step('0, '0, byte_r);
        end else if (byte_r == CH_QUOTE) begin
          mode_nxt = MODE_STRING;
        end else if (byte_r == CH_PLUS) begin
          mode_nxt = MODE_PLUS;
        end
      end
    end

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      len_r       <= '0;
      kwm_r       <= '0;
      pair_r      <= 1'b0;
      tail_on_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      kwm_r       <= kwm_nxt;
      pair_r      <= pair_nxt;
      tail_on_r   <= tail_on_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r        <= byte_nxt;
    kind_r        <= kind_nxt;
    out_kind_r    <= out_kind_nxt;
    out_char_r    <= out_char_nxt;
    out_present_r <= out_present_nxt;
    out_tlast_r   <= out_tlast_nxt;
    out_rlast_r   <= out_rlast_nxt;
  end

  // Token store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = out_kind_r;
  assign out_value_char   = out_char_r;
  assign out_char_present = out_present_r;
  assign out_token_last   = out_tlast_r;
  assign out_run_last     = out_rlast_r;

endmodule

/* sv/stt_ctrl.sv */
// Tokenizer controller: sequences accept, flush, operator and tail phases
`include "source_text_tokenizer_defines.svh"

module stt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stt_pkg::dp_stat_t stat,
  output stt_pkg::dp_cmd_t  cmd
);
  import stt_pkg::*;

  typedef enum logic [3:0] {
    ST_IN    = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_PLUS  = 4'b0100,
    ST_TAIL  = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  assign in_ready = state_r == ST_IN;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IN: begin
        if (accept) begin
          if (stat.in_keep) begin
            cmd.keep_in = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            if (stat.mode_flush)     state_nxt = ST_FLUSH;
            else if (stat.mode_plus) state_nxt = ST_PLUS;
            else                     state_nxt = ST_TAIL;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit_flush = 1'b1;
          if (stat.flush_last) state_nxt = ST_TAIL;
        end
      end
      ST_PLUS: begin
        if (stat.out_free) begin
          cmd.emit_plus = 1'b1;
          if (!stat.pair) state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // hold while the byte's own item cannot be placed
        if (!stat.tail_res || stat.out_free) begin
          cmd.tail_go = 1'b1;
          state_nxt   = ST_IN;
        end
      end
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

  `STT_ASSERT_NOW(a_emit_slot, (cmd.emit_flush || cmd.emit_plus), stat.out_free, "item emitted into a full output register")
  `STT_ASSERT_NEXT(a_flush_entry, (accept && !stat.in_keep && stat.mode_flush), (state_r == ST_FLUSH), "token end did not start a flush")
  `STT_ASSERT_NEXT(a_flush_hold, (state_r == ST_FLUSH && !stat.out_free), (state_r == ST_FLUSH), "flush left while output stalled")
  `STT_ASSERT_NEXT(a_tail_done, cmd.tail_go, in_ready, "not ready for the next item after tail")

endmodule

/* sv/source_text_tokenizer.sv */
// Source text tokenizer top level: controller and datapath
//
//   channel | ports                                          | dir
//   input   | in_valid, in_ready, in_text_byte                | in
//   result  | out_valid, out_ready, out_token_kind,           | out
//           | out_value_char, out_char_present,              |
//           | out_token_last, out_run_last                   |
//
// A byte that extends a token is stored at once. Any other byte first sends each
// stored character or '+' item (an empty string sends one item), then its own
// item, if it has one, in the tail phase. Characters are replayed one per cycle,
// while the result channel is free, from the token store's single read port.
// Reset (rst_n low, synchronous) returns the scanner to idle between tokens.
// A stalled result channel holds the controller in any phase that must place an
// item; input is taken only once all items of the previous byte are in the output register.
module source_text_tokenizer #(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_value_char,
  output logic       out_char_present,
  output logic       out_token_last,
  output logic       out_run_last
);
  import stt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stt_dp #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_text_byte     (in_text_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_value_char   (out_value_char),
    .out_char_present (out_char_present),
    .out_token_last   (out_token_last),
    .out_run_last     (out_run_last)
  );

endmodule
